/* hw/rtl/oxsc_pkg.sv */
// ----------------------------------------------------------------------------
// Oxygen sensor sample conditioner package
// Shared widths, register indexes, reset values, types and the narrowband ROM.
// ----------------------------------------------------------------------------
package oxsc_pkg;

  localparam int unsigned SampleW    = 10;
  localparam int unsigned SumW       = 12;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CodeW      = 6;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 10;
  localparam int unsigned TableDepth = 64;
  localparam int unsigned TableIdxW  = $clog2(TableDepth);

  localparam logic [SampleW-1:0] WbOffsetRst   = SampleW'(400);
  localparam logic [ByteW-1:0]   NbStartRst    = ByteW'(95);
  localparam logic [ByteW-1:0]   TargetTempRst = ByteW'(237);
  localparam logic [ByteW-1:0]   TempWindowRst = ByteW'(5);
  localparam logic [ByteW-1:0]   WbMax         = ByteW'(254);
  localparam logic [ByteW-1:0]   TempFull      = ByteW'(255);

  // floor(x/3) = (x * 2731) >> 13 for x < 4096
  localparam logic [SumW-1:0]    Div3Mul   = SumW'(2731);
  localparam int unsigned        Div3Shift = 13;
  // floor(x/5) = (x * 6554) >> 15 for x < 4096
  localparam logic [14:0]        Div5Mul   = 15'd6554;
  localparam int unsigned        Div5Shift = 15;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WB_OFFSET   = 2'd0,
    REG_NB_START    = 2'd1,
    REG_TARGET_TEMP = 2'd2,
    REG_TEMP_WINDOW = 2'd3
  } oxsc_reg_e;

  typedef struct packed {
    logic [SampleW-1:0] wideband_offset;
    logic [ByteW-1:0]   narrowband_start;
    logic [ByteW-1:0]   target_temperature;
    logic [ByteW-1:0]   temperature_window;
  } oxsc_cfg_t;

  typedef struct packed {
    logic [SampleW-1:0] pump_average;
    logic [SampleW-1:0] nernst_level;
    logic [SampleW-1:0] aux_level;
    logic [SampleW-1:0] dc_level;
  } oxsc_cycle_t;

  typedef struct packed {
    logic [ByteW-1:0]   wideband_level;
    logic [CodeW-1:0]   narrowband_code;
    logic [ByteW-1:0]   heater_temperature;
    logic               temperature_ok;
    logic [SampleW-1:0] pump_average;
    logic [SampleW-1:0] nernst_level;
    logic [SampleW-1:0] aux_level;
  } oxsc_result_t;

  localparam logic [CodeW-1:0] NbRom [TableDepth] = '{
    6'h0B, 6'h0B, 6'h0B, 6'h0B, 6'h0B, 6'h0B, 6'h0B, 6'h0B,
    6'h0B, 6'h0B, 6'h0B, 6'h0B, 6'h0B, 6'h0B, 6'h0B, 6'h0B,
    6'h0B, 6'h0B, 6'h0A, 6'h0A, 6'h0A, 6'h0A, 6'h0A, 6'h0A,
    6'h09, 6'h09, 6'h09, 6'h08, 6'h08, 6'h08, 6'h07, 6'h07,
    6'h05, 6'h05, 6'h04, 6'h04, 6'h04, 6'h03, 6'h03, 6'h03,
    6'h02, 6'h02, 6'h02, 6'h02, 6'h02, 6'h02, 6'h01, 6'h01,
    6'h01, 6'h01, 6'h01, 6'h01, 6'h01, 6'h01, 6'h01, 6'h01,
    6'h01, 6'h01, 6'h01, 6'h01, 6'h01, 6'h01, 6'h01, 6'h01
  };

endpackage

/* hw/rtl/oxsc_if.sv */
// ----------------------------------------------------------------------------
// Oxygen sensor sample conditioner channels
// Valid/ready channels for converter samples and conditioned results.
// ----------------------------------------------------------------------------
interface oxsc_in_if
  import oxsc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] sample;
  logic               cycle_start;

  modport source (output valid, sample, cycle_start, input ready);
  modport sink   (input valid, sample, cycle_start, output ready);
endinterface

interface oxsc_out_if
  import oxsc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ByteW-1:0]   wideband_level;
  logic [CodeW-1:0]   narrowband_code;
  logic [ByteW-1:0]   heater_temperature;
  logic               temperature_ok;
  logic [SampleW-1:0] pump_average;
  logic [SampleW-1:0] nernst_level;
  logic [SampleW-1:0] aux_level;

  modport source (output valid, wideband_level, narrowband_code, heater_temperature,
                  temperature_ok, pump_average, nernst_level, aux_level, input ready);
  modport sink   (input valid, wideband_level, narrowband_code, heater_temperature,
                  temperature_ok, pump_average, nernst_level, aux_level, output ready);
endinterface

/* hw/rtl/oxsc_calc.sv */
// ----------------------------------------------------------------------------
// Oxygen sensor sample conditioner result logic
// Wideband scaling, narrowband lookup, heater temperature and window check.
// ----------------------------------------------------------------------------
module oxsc_calc
  import oxsc_pkg::*;
(
  input  oxsc_cfg_t    cfg_i,
  input  oxsc_cycle_t  cycle_i,
  output oxsc_result_t result_o
);

  logic [SampleW-1:0]    excess;
  logic [SumW-1:0]       excess_x3;
  logic [SumW+14:0]      scaled_prod;
  logic [SumW-1:0]       scaled;
  logic [ByteW-1:0]      wb;
  logic [ByteW:0]        nb_diff;
  logic [TableIdxW-1:0]  nb_idx;
  logic [SampleW:0]      dc_diff;
  logic [ByteW-1:0]      temp;
  logic signed [ByteW+1:0] band_lo;
  logic [ByteW:0]        band_hi;

  always_comb begin
    excess      = (cycle_i.pump_average > cfg_i.wideband_offset)
                ? cycle_i.pump_average - cfg_i.wideband_offset : '0;
    excess_x3   = {1'b0, excess, 1'b0} + {2'b00, excess};
    scaled_prod = excess_x3 * Div5Mul;
    scaled      = scaled_prod[Div5Shift +: SumW];
    wb          = (scaled > {4'b0, WbMax}) ? WbMax : scaled[ByteW-1:0];

    nb_diff = {1'b0, wb} - {1'b0, cfg_i.narrowband_start};
    if (wb < cfg_i.narrowband_start) begin
      nb_idx = '0;
    end else if (nb_diff > (ByteW+1)'(TableDepth - 1)) begin
      nb_idx = TableIdxW'(TableDepth - 1);
    end else begin
      nb_idx = nb_diff[TableIdxW-1:0];
    end

    dc_diff = {1'b0, cycle_i.dc_level} - {1'b0, cycle_i.nernst_level};
    if (cycle_i.dc_level < cycle_i.nernst_level) begin
      temp = '0;
    end else if (dc_diff > (SampleW+1)'(TempFull)) begin
      temp = '0;
    end else begin
      temp = TempFull - dc_diff[ByteW-1:0];
    end

    band_lo = $signed({2'b00, cfg_i.target_temperature})
            - $signed({2'b00, cfg_i.temperature_window});
    band_hi = {1'b0, cfg_i.target_temperature} + {1'b0, cfg_i.temperature_window};

    result_o.wideband_level     = wb;
    result_o.narrowband_code    = NbRom[nb_idx];
    result_o.heater_temperature = temp;
    result_o.temperature_ok     = ($signed({2'b00, temp}) > band_lo)
                                && ({1'b0, temp} < band_hi);
    result_o.pump_average       = cycle_i.pump_average;
    result_o.nernst_level       = cycle_i.nernst_level;
    result_o.aux_level          = cycle_i.aux_level;
  end

endmodule

/* hw/rtl/oxygen_sensor_sample_conditioner_core.sv */
// ----------------------------------------------------------------------------
// Oxygen sensor sample conditioner core
// Sequences converter samples and emits one conditioned result per cycle.
// ----------------------------------------------------------------------------
// Samples enter on in_i, one per transfer, in the order auxiliary (with
// cycle_start set), pump 1..3, Nernst, Nernst with DC test current. The
// transfer of the DC sample produces one result on out_o; all other
// transfers produce none. A cycle_start transfer aborts any running cycle,
// and samples without cycle_start outside a cycle are dropped.
// Throughput: one sample per clock while in_i is ready. The DC sample
// transfer loads the pump average register, then the result register.
// Two result slots decouple the sides: in_i stays ready while a result waits
// on out_o, and only stalls when both slots are full and out_o is held.
// Reset clears the sequence to idle, empties both slots and restores the
// configuration registers (offset 400, start 95, target 237, window 5).
// Configuration writes on cfg_we_i take effect at the next edge and must only
// happen while the block is idle.
// ----------------------------------------------------------------------------
module oxygen_sensor_sample_conditioner_core
  import oxsc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  oxsc_in_if.sink             in_i,
  oxsc_out_if.source          out_o
);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_PUMP1  = 3'd1,
    PH_PUMP2  = 3'd2,
    PH_PUMP3  = 3'd3,
    PH_NERNST = 3'd4,
    PH_DC     = 3'd5
  } phase_e;

  oxsc_cfg_t    cfg_q;
  phase_e       phase_q, phase_d;
  logic [SumW-1:0]    pump_sum_q, pump_sum_d;
  logic [SampleW-1:0] nernst_q, nernst_d;
  logic [SampleW-1:0] aux_q, aux_d;

  logic         in_fire;
  logic         last_sample;
  logic         s1_valid_q;
  logic         s1_ready;
  logic         out_free;
  logic         out_valid_q;
  logic [SumW+SumW-1:0] avg_prod;
  oxsc_cycle_t  s1_q;
  oxsc_result_t result;
  oxsc_result_t out_q;

  assign out_free    = !out_valid_q || out_o.ready;
  assign s1_ready    = !s1_valid_q || out_free;
  assign in_i.ready  = s1_ready;
  assign in_fire     = in_i.valid && s1_ready;
  assign last_sample = in_fire && !in_i.cycle_start && (phase_q == PH_DC);
  assign avg_prod    = pump_sum_q * Div3Mul;

  always_comb begin
    phase_d    = phase_q;
    pump_sum_d = pump_sum_q;
    nernst_d   = nernst_q;
    aux_d      = aux_q;
    if (in_fire) begin
      if (in_i.cycle_start) begin
        aux_d   = in_i.sample;
        phase_d = PH_PUMP1;
      end else begin
        case (phase_q)
          PH_PUMP1: begin
            pump_sum_d = {2'b00, in_i.sample};
            phase_d    = PH_PUMP2;
          end
          PH_PUMP2: begin
            pump_sum_d = pump_sum_q + {2'b00, in_i.sample};
            phase_d    = PH_PUMP3;
          end
          PH_PUMP3: begin
            pump_sum_d = pump_sum_q + {2'b00, in_i.sample};
            phase_d    = PH_NERNST;
          end
          PH_NERNST: begin
            nernst_d = in_i.sample;
            phase_d  = PH_DC;
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wideband_offset    <= WbOffsetRst;
      cfg_q.narrowband_start   <= NbStartRst;
      cfg_q.target_temperature <= TargetTempRst;
      cfg_q.temperature_window <= TempWindowRst;
      phase_q     <= PH_IDLE;
      pump_sum_q  <= '0;
      nernst_q    <= '0;
      aux_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (oxsc_reg_e'(cfg_index_i))
          REG_WB_OFFSET:   cfg_q.wideband_offset    <= cfg_data_i[SampleW-1:0];
          REG_NB_START:    cfg_q.narrowband_start   <= cfg_data_i[ByteW-1:0];
          REG_TARGET_TEMP: cfg_q.target_temperature <= cfg_data_i[ByteW-1:0];
          REG_TEMP_WINDOW: cfg_q.temperature_window <= cfg_data_i[ByteW-1:0];
          default: ;
        endcase
      end
      phase_q    <= phase_d;
      pump_sum_q <= pump_sum_d;
      nernst_q   <= nernst_d;
      aux_q      <= aux_d;
      if (s1_ready) begin
        s1_valid_q <= last_sample;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (last_sample) begin
      s1_q.pump_average <= avg_prod[Div3Shift +: SampleW];
      s1_q.nernst_level <= nernst_q;
      s1_q.aux_level    <= aux_q;
      s1_q.dc_level     <= in_i.sample;
    end
    if (s1_valid_q && out_free) begin
      out_q <= result;
    end
  end

  oxsc_calc u_calc (
    .cfg_i    (cfg_q),
    .cycle_i  (s1_q),
    .result_o (result)
  );

  assign out_o.valid              = out_valid_q;
  assign out_o.wideband_level     = out_q.wideband_level;
  assign out_o.narrowband_code    = out_q.narrowband_code;
  assign out_o.heater_temperature = out_q.heater_temperature;
  assign out_o.temperature_ok     = out_q.temperature_ok;
  assign out_o.pump_average       = out_q.pump_average;
  assign out_o.nernst_level       = out_q.nernst_level;
  assign out_o.aux_level          = out_q.aux_level;

endmodule
